// ===== src/gha_pkg.sv =====
// Shared widths, register codes and item types for the GHASH accumulator.
`timescale 1ns / 1ps

package gha_pkg;

   // Width of one message half and of the full GF(2^128) element.
   localparam int HalfW  = 64;
   localparam int BlockW = 2 * HalfW;

   // Configuration register index width and register codes.
   localparam int CsrIdxW = 1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_reg_type;

   // One message block as it sits in the input register.
   typedef struct packed {
      logic [BlockW-1:0] block;
      logic              start_msg;
      logic              last_block;
   } item_type;

endpackage

// ===== src/gha_key_regs.sv =====
// Hash key registers written through the configuration channel.
`timescale 1ns / 1ps

module gha_key_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [gha_pkg::CsrIdxW-1:0] csr_index,
   input  logic [gha_pkg::HalfW-1:0]   csr_wdata,
   output logic [gha_pkg::BlockW-1:0]  hash_key
);

   logic [gha_pkg::HalfW-1:0] key_high_ff;
   logic [gha_pkg::HalfW-1:0] key_low_ff;
   logic [gha_pkg::HalfW-1:0] key_high_in;
   logic [gha_pkg::HalfW-1:0] key_low_in;

   // Writes never wait.
   assign csr_ready = 1'b1;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_valid) begin
         unique case (gha_pkg::csr_reg_type'(csr_index))
            gha_pkg::CSR_KEY_HIGH: key_high_in = csr_wdata;
            gha_pkg::CSR_KEY_LOW:  key_low_in  = csr_wdata;
            default: begin
               key_high_in = key_high_ff;
               key_low_in  = key_low_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   assign hash_key = {key_high_ff, key_low_ff};

endmodule

// ===== src/gha_gf_mult.sv =====
// Combinational GF(2^128) multiplier in the bit-reflected GCM convention.
`timescale 1ns / 1ps

module gha_gf_mult (
   input  logic [gha_pkg::BlockW-1:0] op_x,
   input  logic [gha_pkg::BlockW-1:0] op_h,
   output logic [gha_pkg::BlockW-1:0] product
);

   localparam int W  = gha_pkg::BlockW;
   localparam int PW = 2 * W - 1;

   // GCM stores the coefficient of x^0 in the most significant bit.
   function automatic logic [W-1:0] reflect(input logic [W-1:0] v);
      logic [W-1:0] r;
      for (int i = 0; i < W; i++) begin
         r[i] = v[W-1-i];
      end
      return r;
   endfunction

   // Carryless product: each output bit is the parity of its AND terms.
   function automatic logic [PW-1:0] clmul(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [PW-1:0] c;
      logic [W-1:0]  t;
      for (int k = 0; k < PW; k++) begin
         t = '0;
         for (int i = 0; i < W; i++) begin
            if ((k - i >= 0) && (k - i < W)) begin
               t[i] = a[i] & b[k-i];
            end
         end
         c[k] = ^t;
      end
      return c;
   endfunction

   // Reduce modulo x^128 + x^7 + x^2 + x + 1. The upper half is folded back
   // by (1 + x + x^2 + x^7); the few bits that spill past x^127 fold once more.
   function automatic logic [W-1:0] reduce(input logic [PW-1:0] c);
      logic [W-2:0] hi;
      logic [W+5:0] f;
      logic [5:0]   ov;
      logic [12:0]  g;
      hi = c[PW-1:W];
      f  = {7'b0, hi} ^ {6'b0, hi, 1'b0} ^ {5'b0, hi, 2'b0} ^ {hi, 7'b0};
      ov = f[W+5:W];
      g  = {7'b0, ov} ^ {6'b0, ov, 1'b0} ^ {5'b0, ov, 2'b0} ^ {ov, 7'b0};
      return c[W-1:0] ^ f[W-1:0] ^ {{(W-13){1'b0}}, g};
   endfunction

   assign product = reflect(reduce(clmul(reflect(op_x), reflect(op_h))));

endmodule

// ===== src/ghash_accumulator_unit.sv =====
// Top level of the GHASH accumulator: input register, GF multiply, result register.
`timescale 1ns / 1ps

// The block computes the GCM GHASH over a message of 128-bit blocks.
// The hash key H is written through the csr_ channel: index 0 holds the upper
// 64 bits (byte 0 most significant), index 1 the lower 64 bits. The channel is
// always ready, and a new key applies to every block absorbed after the write.
// Each item on the req_ channel carries one block as two halves plus the
// start_msg and last_block flags. Start clears the accumulator before the
// block is XORed in; the sum is then multiplied by H in GF(2^128). An item
// with last_block set produces one rsp_ item holding the digest; other items
// produce none, and the accumulator is never cleared by a digest.
// From req_ acceptance to rsp_valid the item is first held in the input
// register and then passes through the multiplier into the accumulator and
// result register, from which its digest can be taken. Throughput is one item
// per cycle while req_stall is low, set by the combinational multiply that
// feeds the accumulator back to itself.
// When the receiver stalls with a digest pending, items without last_block
// still pass through; the next last_block item waits in the input register
// and req_stall rises until the pending digest is taken.
// Synchronous reset clears the key, the accumulator and both valid flags.
module ghash_accumulator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [gha_pkg::HalfW-1:0]   req_block_high,
   input  logic [gha_pkg::HalfW-1:0]   req_block_low,
   input  logic                        req_start_msg,
   input  logic                        req_last_block,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [gha_pkg::HalfW-1:0]   rsp_digest_high,
   output logic [gha_pkg::HalfW-1:0]   rsp_digest_low,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [gha_pkg::CsrIdxW-1:0] csr_index,
   input  logic [gha_pkg::HalfW-1:0]   csr_wdata
);

   localparam int HW = gha_pkg::HalfW;
   localparam int BW = gha_pkg::BlockW;

   logic [BW-1:0]     hash_key;
   logic [BW-1:0]     mult_in;
   logic [BW-1:0]     mult_out;

   gha_pkg::item_type stage_ff;
   gha_pkg::item_type stage_in;
   logic              stage_valid_ff;
   logic              stage_valid_in;
   logic [BW-1:0]     acc_ff;
   logic [BW-1:0]     acc_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [BW-1:0]     out_digest_ff;
   logic [BW-1:0]     out_digest_in;

   logic              req_take;
   logic              consume;
   logic              out_free;

   gha_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .hash_key  (hash_key)
   );

   // The item in the input register can move on unless it must produce a
   // digest while the result register still holds one that is not taken.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign consume   = stage_valid_ff && (!stage_ff.last_block || out_free);
   assign req_stall = stage_valid_ff && !consume;
   assign req_take  = req_valid && !req_stall;

   // Start drops the old sum before this block is XORed in.
   assign mult_in = (stage_ff.start_msg ? '0 : acc_ff) ^ stage_ff.block;

   gha_gf_mult u_gf_mult (
      .op_x    (mult_in),
      .op_h    (hash_key),
      .product (mult_out)
   );

   always_comb begin
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_in.block      = {req_block_high, req_block_low};
         stage_in.start_msg  = req_start_msg;
         stage_in.last_block = req_last_block;
         stage_valid_in      = 1'b1;
      end else if (consume) begin
         stage_valid_in      = 1'b0;
      end
   end

   always_comb begin
      acc_in        = acc_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_digest_in = out_digest_ff;
      if (consume) begin
         acc_in = mult_out;
         if (stage_ff.last_block) begin
            out_valid_in  = 1'b1;
            out_digest_in = mult_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         acc_ff         <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         acc_ff         <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff      <= stage_in;
      out_digest_ff <= out_digest_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_digest_high = out_digest_ff[BW-1:HW];
   assign rsp_digest_low  = out_digest_ff[HW-1:0];

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff && stage_ff.last_block)
      else $error("input stalled without a pending last block");

   a_no_last_flows: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_ff.last_block |-> consume)
      else $error("block without digest was held back");

   a_last_loads_result: assert property (@(posedge clock) disable iff (reset)
      consume && stage_ff.last_block |=> out_valid_ff && (out_digest_ff == acc_ff))
      else $error("digest not loaded from the new accumulator");

   a_acc_holds: assert property (@(posedge clock) disable iff (reset)
      !consume |=> $stable(acc_ff))
      else $error("accumulator changed with no block absorbed");
`endif

endmodule
